// ----- rtl/core/ngcp_pkg.sv -----
// ----------------------------------------------------------------------------
// ngcp_pkg
// Shared types and constants for the n-gram count-table predictor.
// ----------------------------------------------------------------------------
package ngcp_pkg;

  localparam logic [1:0] ACT_TRAIN   = 2'd0;
  localparam logic [1:0] ACT_PREDICT = 2'd1;
  localparam logic [1:0] ACT_CONTEXT = 2'd2;
  localparam logic [1:0] ACT_CLEAR   = 2'd3;

  localparam logic [1:0] LVL_QUAD = 2'd0;
  localparam logic [1:0] LVL_TRI  = 2'd1;
  localparam logic [1:0] LVL_BI   = 2'd2;
  localparam logic [1:0] LVL_UNI  = 2'd3;

  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [15:0] SCORE_SCALE = 16'hFFFF;

  localparam logic [1:0] REG_SLOTS  = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_SMOOTH = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,     // sweep memories after reset
    ST_IDLE,
    ST_UNI_RD,    // unigram read issued
    ST_UNI_WR,    // unigram update
    ST_SCAN,      // slot scan of current level
    ST_SCAN_END,  // last read data arrives
    ST_LEARN,     // write back learned slot
    ST_DIV_GO,    // launch the division on the settled sums
    ST_DIV,       // confidence division
    ST_JUDGE,     // fold level into cascade
    ST_OUT        // hold result
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       clr_start;
    logic       clr_step;
    logic       take;       // latch input item
    logic       uni_rd;
    logic       uni_wr;
    logic       scan_start;
    logic       scan_step;
    logic       scan_last;
    logic       learn_wr;
    logic       div_start;
    logic       judge;
    logic       next_level;
    logic       finish;     // latch result
    logic       push;
    logic       zero_ctx;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic       clr_done;
    logic       scan_done;
    logic       div_done;
    logic       level_empty;
    logic       stop;       // cascade stops after this level
    logic [1:0] level;
  } stat_t;

  function automatic logic [15:0] mix_one(input logic [15:0] a);
    logic [31:0] h;
    h = {16'd0, a};
    h = h ^ (h << 7); h = h ^ (h >> 9); h = h ^ (h << 3);
    return h[15:0];
  endfunction

  function automatic logic [15:0] mix_two(input logic [15:0] b, input logic [15:0] a);
    logic [31:0] h;
    h = {b, a};
    h = h ^ (h >> 11); h = h ^ (h << 7); h = h ^ (h >> 5);
    return h[15:0];
  endfunction

  function automatic logic [15:0] mix_three(input logic [15:0] c, input logic [15:0] b,
                                            input logic [15:0] a);
    logic [31:0] h;
    h = {c, 16'd0} ^ {8'd0, b, 8'd0} ^ {16'd0, a};
    h = h ^ (h >> 13); h = h ^ (h << 5); h = h ^ (h >> 9);
    return h[15:0];
  endfunction

endpackage

// ----- rtl/core/ngram_count_table_predictor.sv -----
// ----------------------------------------------------------------------------
// ngram_count_table_predictor
// N-gram backoff predictor with per-bucket frequent-item counters.
//
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tdata: word_id[15:0]; tuser: action[1:0]
// m_axis   | out | m_axis_tvalid/tready   | tdata: predicted_word, confidence, level
// apb      | in  | psel/penable/pwrite    | slots_in_use, threshold, smoothing
//
// One item at a time: after it is taken, training updates the unigram table and
// then scans and writes back each level; prediction scans the levels in turn,
// running the bit-serial divider on a level that holds any count; context and
// clear go straight to the result. Reset starts a clearing pass of
// max(2^LOG2_BUCKETS * MAX_SLOTS rounded up to a power of two, VOCAB_ENTRIES)
// addresses; no item is taken during it. The result is held until m_axis_tready.
// ----------------------------------------------------------------------------
module ngram_count_table_predictor
  import ngcp_pkg::*;
#(
  parameter int LOG2_BUCKETS  = 12,
  parameter int MAX_SLOTS     = 16,
  parameter int VOCAB_ENTRIES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // word_id[15:0]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // predicted_word[15:0], confidence[31:16], source_level[33:32]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0]  slots_in_use;
  logic [15:0] confidence_threshold;
  logic [7:0]  confidence_smoothing;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use         <= 5'd16;
      confidence_threshold <= 16'hB000;
      confidence_smoothing <= 8'd4;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SLOTS:  slots_in_use         <= pwdata[4:0];
        REG_THRESH: confidence_threshold <= pwdata[15:0];
        REG_SMOOTH: confidence_smoothing <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_SLOTS:  prdata = {27'd0, slots_in_use};
      REG_THRESH: prdata = {16'd0, confidence_threshold};
      REG_SMOOTH: prdata = {24'd0, confidence_smoothing};
      default:    prdata = '0;
    endcase
  end

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire, out_fire;
  logic [15:0] pw, cf;
  logic [1:0]  sl;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {6'd0, sl, cf, pw};

  ngcp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_action(s_axis_tuser),
    .out_fire(out_fire), .stat(stat), .cmd(cmd),
    .busy_n(s_axis_tready), .out_valid(m_axis_tvalid));

  ngcp_datapath #(
    .LOG2_BUCKETS(LOG2_BUCKETS), .MAX_SLOTS(MAX_SLOTS), .VOCAB_ENTRIES(VOCAB_ENTRIES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(s_axis_tdata),
    .slots_in_use(slots_in_use), .threshold(confidence_threshold),
    .smoothing(confidence_smoothing), .stat(stat),
    .predicted_word(pw), .confidence(cf), .source_level(sl));

`ifndef SYNTHESIS
  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_unigram_no_conf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33:32] == LVL_UNI |-> m_axis_tdata[31:16] == 16'd0)
    else $error("unigram fallback with nonzero confidence");
`endif
endmodule

// ----- rtl/core/ngcp_ram.sv -----
// ----------------------------------------------------------------------------
// ngcp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ngcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/ngcp_divider.sv -----
// ----------------------------------------------------------------------------
// ngcp_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ngcp_divider
  import ngcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [32:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quotient[31]};
  assign diff    = shifted - {1'b0, dsr};

  // Shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[32]) begin
        rem      <= diff;
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/core/ngcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ngcp_ctrl
// Sequencer for clearing, training and the prediction cascade.
// ----------------------------------------------------------------------------
module ngcp_ctrl
  import ngcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] in_action,
  input  logic       out_fire,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy_n,   // ready for an item
  output logic       out_valid
);
  state_t state, state_next;
  logic   first;
  logic   cmd_train_q;

  // Mark the first cycle after reset to launch the clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      first <= 1'b1;
    end else begin
      state <= state_next;
      first <= 1'b0;
    end
  end

  // Remember whether the running item trains
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_train_q <= 1'b0;
    end else if (state == ST_IDLE && in_fire) begin
      cmd_train_q <= (in_action == ACT_TRAIN);
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy_n     = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_start = first;
        cmd.clr_step  = !first;
        if (!first && stat.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy_n = 1'b1;
        if (in_fire) begin
          cmd.take = 1'b1;
          unique case (in_action)
            ACT_TRAIN:   state_next = ST_UNI_RD;
            ACT_PREDICT: state_next = ST_SCAN;
            default:     state_next = ST_OUT;
          endcase
          if (in_action == ACT_TRAIN || in_action == ACT_PREDICT) cmd.scan_start = 1'b1;
        end
      end
      ST_UNI_RD: begin
        cmd.uni_rd = 1'b1;
        state_next = ST_UNI_WR;
      end
      ST_UNI_WR: begin
        cmd.uni_wr     = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        cmd.scan_last = 1'b1;
        // training writes back instead of dividing
        if (cmd_train_q) state_next = ST_LEARN;
        else state_next = ST_DIV_GO;
      end
      ST_LEARN: begin
        cmd.learn_wr = 1'b1;
        if (stat.level == LVL_BI) begin
          cmd.push   = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.next_level = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_DIV_GO: begin
        // skip the division for a level with no counts
        if (stat.level_empty) begin
          state_next = ST_JUDGE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge = 1'b1;
        if (stat.stop || stat.level == LVL_BI) begin
          cmd.finish = 1'b1;
          state_next = ST_OUT;
        end else begin
          cmd.next_level = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_IDLE && in_fire && in_action == ACT_CONTEXT) cmd.push = 1'b1;
    if (state == ST_IDLE && in_fire && in_action == ACT_CLEAR) cmd.zero_ctx = 1'b1;
  end
endmodule

// ----- rtl/core/ngcp_datapath.sv -----
// ----------------------------------------------------------------------------
// ngcp_datapath
// Slot tables, unigram table, context, scan registers and cascade result.
// ----------------------------------------------------------------------------
module ngcp_datapath
  import ngcp_pkg::*;
#(
  parameter int LOG2_BUCKETS  = 12,
  parameter int MAX_SLOTS     = 16,
  parameter int VOCAB_ENTRIES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [15:0] in_word,
  input  logic [4:0]  slots_in_use,
  input  logic [15:0] threshold,
  input  logic [7:0]  smoothing,
  output stat_t       stat,
  output logic [15:0] predicted_word,
  output logic [15:0] confidence,
  output logic [1:0]  source_level
);
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int TD = 1 << (LOG2_BUCKETS + SW);
  localparam int TA = LOG2_BUCKETS + SW;
  localparam int VA = $clog2(VOCAB_ENTRIES);
  localparam int CA = (TA > VA) ? TA : VA;

  // Context and item registers
  logic [15:0] ctx0, ctx1, ctx2, word;
  logic [1:0]  level;
  logic [15:0] hb_full, ht_full, hq_full;
  logic [LOG2_BUCKETS-1:0] hq, ht, hb, bucket;

  assign hb_full = mix_one(ctx0);
  assign ht_full = mix_two(ctx1, ctx0);
  assign hq_full = mix_three(ctx2, ctx1, ctx0);
  assign hb = hb_full[LOG2_BUCKETS-1:0];
  assign ht = ht_full[LOG2_BUCKETS-1:0];
  assign hq = hq_full[LOG2_BUCKETS-1:0];

  always_comb begin
    case (level)
      LVL_QUAD: bucket = hq;
      LVL_TRI:  bucket = ht;
      default:  bucket = hb;
    endcase
  end

  // Shift or clear the context; a context-only request pushes the word being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx0 <= '0; ctx1 <= '0; ctx2 <= '0;
    end else if (cmd.zero_ctx) begin
      ctx0 <= '0; ctx1 <= '0; ctx2 <= '0;
    end else if (cmd.push) begin
      ctx2 <= ctx1; ctx1 <= ctx0; ctx0 <= cmd.take ? in_word : word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      word <= in_word;
    end
  end

  // Scan width clamp
  logic [6:0] n_scan;
  always_comb begin
    if (slots_in_use == 5'd0) n_scan = 7'd1;
    else if ({2'd0, slots_in_use} > 7'(MAX_SLOTS)) n_scan = 7'(MAX_SLOTS);
    else n_scan = {2'd0, slots_in_use};
  end

  // Clear sweep counter
  logic [CA:0] clr_cnt;
  logic        clearing;
  logic        clr_done;
  assign clr_done = (clr_cnt == (CA+1)'(TD > VOCAB_ENTRIES ? TD : VOCAB_ENTRIES) - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b0;
    end else if (cmd.clr_start) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_done) clearing <= 1'b0;
    end
  end

  // Scan counters: issue index and returned index
  logic [6:0] rd_idx, rv_idx;
  logic       rv_valid;
  logic       scan_done;
  assign scan_done = (rd_idx == n_scan - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= LVL_QUAD;
      rd_idx   <= '0;
      rv_valid <= 1'b0;
      rv_idx   <= '0;
    end else begin
      if (cmd.take) level <= LVL_QUAD;
      else if (cmd.next_level) level <= level + 2'd1;
      rv_valid <= cmd.scan_step;
      rv_idx   <= rd_idx;
      if (cmd.scan_start) rd_idx <= '0;
      else if (cmd.scan_step && !scan_done) rd_idx <= rd_idx + 7'd1;
    end
  end

  // Slot memories, a word RAM and a count RAM per level
  logic [TA-1:0] taddr;
  logic [TA-1:0] rd_addr;
  logic [TA-1:0] wr_addr;
  logic [15:0]   wr_word, wr_cnt;
  logic [15:0]   rw [3];
  logic [15:0]   rc [3];

  assign rd_addr = TA'({bucket, rd_idx[SW-1:0]});

  always_comb begin
    if (clearing) taddr = clr_cnt[TA-1:0];
    else if (cmd.learn_wr) taddr = wr_addr;
    else taddr = rd_addr;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lvl
    logic we;
    assign we = (clearing && clr_cnt < (CA+1)'(TD)) || (cmd.learn_wr && level == 2'(g));
    ngcp_ram #(.WIDTH(16), .DEPTH(TD)) u_words (
      .clk(clk), .we(we), .addr(taddr), .wdata(clearing ? 16'd0 : wr_word), .rdata(rw[g]));
    ngcp_ram #(.WIDTH(16), .DEPTH(TD)) u_counts (
      .clk(clk), .we(we), .addr(taddr), .wdata(clearing ? 16'd0 : wr_cnt), .rdata(rc[g]));
  end

  logic [15:0] cur_w, cur_c;
  assign cur_w = rw[level];
  assign cur_c = rc[level];

  // Scan accumulators
  logic        hit, have_free;
  logic [SW-1:0] hit_at, free_at, min_at;
  logic [15:0] hit_c, min_c, min_slot_c, best_c, best_w;
  logic [31:0] total;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit <= 1'b0; have_free <= 1'b0;
      hit_at <= '0; free_at <= '0; min_at <= '0;
      hit_c <= '0; min_c <= COUNT_MAX; min_slot_c <= '0;
      best_c <= '0; best_w <= '0; total <= '0;
    end else if (rv_valid) begin
      total <= total + {16'd0, cur_c};
      if (cur_c > best_c) begin
        best_c <= cur_c; best_w <= cur_w;
      end
      if (rv_idx == 7'd0) min_slot_c <= cur_c;
      if (!hit) begin
        if (cur_c == 16'd0) begin
          if (!have_free) begin
            have_free <= 1'b1; free_at <= rv_idx[SW-1:0];
          end
        end else if (cur_w == word) begin
          hit <= 1'b1; hit_at <= rv_idx[SW-1:0]; hit_c <= cur_c;
        end else if (cur_c < min_c) begin
          min_c <= cur_c; min_at <= rv_idx[SW-1:0]; min_slot_c <= cur_c;
        end
      end
    end
  end

  // Word at the minimum slot, kept for decrement write-back
  logic [15:0] min_at_w;
  always_ff @(posedge clk) begin
    if (rv_valid && !hit && cur_c != 16'd0 && cur_w != word &&
        (cur_c < min_c || rv_idx == 7'd0)) begin
      min_at_w <= cur_w;
    end
  end

  // Learn decision
  always_comb begin
    wr_word = word;
    wr_cnt  = 16'd1;
    wr_addr = TA'({bucket, free_at});
    if (hit) begin
      wr_addr = TA'({bucket, hit_at});
      wr_cnt  = (hit_c == COUNT_MAX) ? hit_c : hit_c + 16'd1;
    end else if (!have_free) begin
      wr_addr = TA'({bucket, min_at});
      if (min_slot_c > 16'd1) begin
        wr_cnt  = min_slot_c - 16'd1;
        wr_word = min_at_w;
      end
    end
  end

  // Unigram table and running argmax
  logic [31:0] uni_rd, top_c, uni_new;
  logic [15:0] top_w;
  logic        in_vocab;
  logic [VA-1:0] uaddr;
  assign in_vocab = ({16'd0, word} < 32'(VOCAB_ENTRIES));
  assign uaddr    = clearing ? clr_cnt[VA-1:0] : word[VA-1:0];
  assign uni_new  = (uni_rd == 32'hFFFF_FFFF) ? uni_rd : uni_rd + 32'd1;

  ngcp_ram #(.WIDTH(32), .DEPTH(VOCAB_ENTRIES)) u_uni (
    .clk(clk),
    .we((clearing && clr_cnt < (CA+1)'(VOCAB_ENTRIES)) || (cmd.uni_wr && in_vocab)),
    .addr(uaddr), .wdata(clearing ? 32'd0 : uni_new), .rdata(uni_rd));

  always_ff @(posedge clk) begin
    if (rst) begin
      top_c <= '0; top_w <= '0;
    end else if (cmd.uni_wr && in_vocab &&
                 (uni_new > top_c || (uni_new == top_c && word < top_w))) begin
      top_c <= uni_new; top_w <= word;
    end
  end

  // Confidence division
  logic        div_done;
  logic [31:0] quot;
  ngcp_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend({16'd0, best_c} * {16'd0, SCORE_SCALE}),
    .divisor(total + {24'd0, smoothing}),
    .done(div_done), .quotient(quot));

  // Cascade best
  logic [31:0] run_sc;
  logic [15:0] run_w;
  logic [1:0]  run_lvl;
  logic        nonempty;
  logic        level_empty;
  logic        stop;
  assign level_empty = (total == 32'd0);
  assign nonempty    = !level_empty;
  assign stop = nonempty && ((quot > run_sc ? quot : run_sc) >= {16'd0, threshold})
                && level != LVL_BI;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      run_sc <= '0; run_w <= '0; run_lvl <= LVL_QUAD;
    end else if (cmd.judge && nonempty && quot > run_sc) begin
      run_sc <= quot; run_w <= best_w; run_lvl <= level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      predicted_word <= '0; confidence <= '0; source_level <= LVL_QUAD;
    end else if (cmd.finish) begin
      if (stop || run_sc != 32'd0 || (nonempty && quot > run_sc)) begin
        if (nonempty && quot > run_sc) begin
          predicted_word <= best_w; confidence <= quot[15:0]; source_level <= level;
        end else begin
          predicted_word <= run_w; confidence <= run_sc[15:0]; source_level <= run_lvl;
        end
      end else begin
        predicted_word <= top_w; confidence <= '0; source_level <= LVL_UNI;
      end
    end
  end

  // Status to the controller
  assign stat = {clr_done, scan_done, div_done, level_empty, stop, level};
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the n-gram count-table predictor: train, predict, context
// and clear requests with random content go in while both sides stall at
// random. A local copy of the count tables predicts every result, which is
// checked field by field in arrival order. Slots, threshold and smoothing
// are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import ngcp_pkg::*;

  typedef struct {
    logic [1:0]  act;
    logic [15:0] word;
  } request_t;

  typedef struct packed {
    logic [1:0]  lvl;
    logic [15:0] conf;
    logic [15:0] word;
  } result_t;

  localparam int WATCHDOG_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // word_id[15:0]
  logic [1:0]  s_axis_tuser = '0;   // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // predicted_word[15:0], confidence[31:16], level[33:32]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ngram_count_table_predictor DUT (.*);

  // local copy of the tables: index 0 bigram, 1 trigram, 2 quadgram
  logic [15:0] gram_word  [3][65536];
  logic [15:0] gram_count [3][65536];
  logic [31:0] uni_count  [65536];
  logic [31:0] top_count;
  logic [15:0] top_word;
  logic [15:0] ctx [3];
  logic [4:0]  slots_cfg;
  logic [15:0] thresh_cfg;
  logic [7:0]  smooth_cfg;

  request_t pending_requests[$];
  result_t  expected_results[$];
  int  sender_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  req_taken = 1'b0;
  int  fail_count = 0;
  int  quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [11:0] hash_bi(logic [15:0] a);
    logic [31:0] h;
    h = {16'd0, a};
    h = h ^ (h << 7); h = h ^ (h >> 9); h = h ^ (h << 3);
    return h[11:0];
  endfunction

  function automatic logic [11:0] hash_tri(logic [15:0] b, logic [15:0] a);
    logic [31:0] h;
    h = {b, a};
    h = h ^ (h >> 11); h = h ^ (h << 7); h = h ^ (h >> 5);
    return h[11:0];
  endfunction

  function automatic logic [11:0] hash_quad(logic [15:0] c, logic [15:0] b, logic [15:0] a);
    logic [31:0] h;
    h = ({16'd0, c} << 16) ^ ({16'd0, b} << 8) ^ {16'd0, a};
    h = h ^ (h >> 13); h = h ^ (h << 5); h = h ^ (h >> 9);
    return h[11:0];
  endfunction

  function automatic int scan_slots();
    if (slots_cfg == 0) return 1;
    if (slots_cfg > 16) return 16;
    return slots_cfg;
  endfunction

  // update one bucket: bump a match, fill a free slot, else age the weakest or replace it at count one
  function automatic void learn_slot(int lvl, logic [11:0] bucket, logic [15:0] w);
    int n, base, free_at, min_at;
    bit have_free;
    logic [15:0] min_c, c;
    n = scan_slots();
    base = bucket * 16;
    have_free = 0; free_at = 0; min_at = 0; min_c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = gram_count[lvl][base + i];
      if (c == 0) begin
        if (!have_free) begin
          have_free = 1; free_at = i;
        end
      end else if (gram_word[lvl][base + i] == w) begin
        if (c != 16'hFFFF) gram_count[lvl][base + i] = c + 16'd1;
        return;
      end else if (c < min_c) begin
        min_c = c; min_at = i;
      end
    end
    if (have_free) begin
      gram_word[lvl][base + free_at] = w;
      gram_count[lvl][base + free_at] = 16'd1;
    end else if (gram_count[lvl][base + min_at] > 1) begin
      gram_count[lvl][base + min_at] = gram_count[lvl][base + min_at] - 16'd1;
    end else begin
      gram_word[lvl][base + min_at] = w;
      gram_count[lvl][base + min_at] = 16'd1;
    end
  endfunction

  // score one bucket; returns 0 when all scanned counts are zero
  function automatic bit guess_slot(int lvl, logic [11:0] bucket,
                                    output logic [31:0] score, output logic [15:0] winner);
    int base;
    logic [31:0] total, best, c;
    logic [63:0] num;
    base = bucket * 16;
    total = 0; best = 0; winner = 0; score = 0;
    for (int i = 0; i < scan_slots(); i++) begin
      c = {16'd0, gram_count[lvl][base + i]};
      total = total + c;
      if (c > best) begin
        best = c; winner = gram_word[lvl][base + i];
      end
    end
    if (total == 0) return 0;
    num = {32'd0, best} * 64'hFFFF;
    score = 32'(num / ({32'd0, total} + {56'd0, smooth_cfg}));
    return 1;
  endfunction

  function automatic result_t predict_next(logic [1:0] act, logic [15:0] w);
    result_t r;
    logic [11:0] hb, ht, hq;
    logic [31:0] best_sc, sc;
    logic [15:0] best_w, cand;
    logic [1:0]  lvl;
    bit done;
    logic [31:0] u;
    r = '0;
    hb = hash_bi(ctx[0]);
    ht = hash_tri(ctx[1], ctx[0]);
    hq = hash_quad(ctx[2], ctx[1], ctx[0]);
    case (act)
      ACT_TRAIN: begin
        u = uni_count[w];
        if (u != 32'hFFFF_FFFF) u = u + 1;
        uni_count[w] = u;
        if (u > top_count || (u == top_count && w < top_word)) begin
          top_count = u; top_word = w;
        end
        learn_slot(0, hb, w);
        learn_slot(1, ht, w);
        learn_slot(2, hq, w);
        ctx[2] = ctx[1]; ctx[1] = ctx[0]; ctx[0] = w;
      end
      ACT_PREDICT: begin
        best_sc = 0; best_w = 0; lvl = LVL_QUAD; done = 0;
        if (guess_slot(2, hq, sc, cand)) begin
          if (sc > best_sc) begin
            best_sc = sc; best_w = cand; lvl = LVL_QUAD;
          end
          if (best_sc >= thresh_cfg) done = 1;
        end
        if (!done && guess_slot(1, ht, sc, cand)) begin
          if (sc > best_sc) begin
            best_sc = sc; best_w = cand; lvl = LVL_TRI;
          end
          if (best_sc >= thresh_cfg) done = 1;
        end
        if (!done && guess_slot(0, hb, sc, cand)) begin
          if (sc > best_sc) begin
            best_sc = sc; best_w = cand; lvl = LVL_BI;
          end
        end
        if (done || best_sc != 0) begin
          r.word = best_w; r.conf = best_sc[15:0]; r.lvl = lvl;
        end else begin
          r.word = top_word; r.conf = 0; r.lvl = LVL_UNI;
        end
      end
      ACT_CONTEXT: begin
        ctx[2] = ctx[1]; ctx[1] = ctx[0]; ctx[0] = w;
      end
      default: begin
        ctx[0] = 0; ctx[1] = 0; ctx[2] = 0;
      end
    endcase
    return r;
  endfunction

  // drive the request side; hold a request until it is taken
  always @(negedge clk) begin
    request_t nxt;
    if (!rst && (!s_axis_tvalid || req_taken)) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.word;
        s_axis_tuser  <= nxt.act;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // watch both sides, predict on accept, check on delivery
  always @(posedge clk) begin
    result_t got, want;
    req_taken = s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      expected_results.push_back(predict_next(s_axis_tuser, s_axis_tdata));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[33:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.word != want.word)
          $display("%0t: predicted_word exp %h got %h", $time, want.word, got.word);
        if (got.conf != want.conf)
          $display("%0t: confidence exp %h got %h", $time, want.conf, got.conf);
        if (got.lvl != want.lvl)
          $display("%0t: source_level exp %0d got %0d", $time, want.lvl, got.lvl);
        if (got != want) fail_count++;
      end
    end
    if (req_taken || (m_axis_tvalid && m_axis_tready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold off until every request is out and every result is back
  task automatic wait_idle();
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SLOTS:  slots_cfg  = value[4:0];
      REG_THRESH: thresh_cfg = value[15:0];
      default:    smooth_cfg = value[7:0];
    endcase
  endtask

  task automatic add_request(logic [1:0] act, logic [15:0] w);
    request_t r;
    r.act = act; r.word = w;
    pending_requests.push_back(r);
  endtask

  // mostly a small vocabulary so contexts recur; some noise and clears
  task automatic add_random(int count);
    int pick;
    logic [15:0] w;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      if (pick < 60) add_request(ACT_TRAIN, w);
      else if (pick < 85) add_request(ACT_PREDICT, 16'($urandom));
      else if (pick < 93) add_request(ACT_CONTEXT, w);
      else add_request(ACT_CLEAR, 16'($urandom));
    end
  endtask

  task automatic run_phase(logic [4:0] slots, logic [15:0] thresh, logic [7:0] smooth,
                           int count);
    wait_idle();
    write_reg(REG_SLOTS, {27'd0, slots});
    write_reg(REG_THRESH, {16'd0, thresh});
    write_reg(REG_SMOOTH, {24'd0, smooth});
    add_random(count);
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) begin
      for (int l = 0; l < 3; l++) begin
        gram_word[l][i] = 0; gram_count[l][i] = 0;
      end
      uni_count[i] = 0;
    end
    top_count = 0; top_word = 0;
    ctx[0] = 0; ctx[1] = 0; ctx[2] = 0;
    slots_cfg = 5'd16; thresh_cfg = 16'hB000; smooth_cfg = 8'd4;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct = 20; recv_idle_pct = 49;

    // fallback on empty tables, word extremes, every action
    add_request(ACT_PREDICT, 16'h0000);
    add_request(ACT_TRAIN, 16'hFFFF);
    add_request(ACT_TRAIN, 16'h0000);
    add_request(ACT_PREDICT, 16'hFFFF);
    add_request(ACT_CONTEXT, 16'hAAAA);
    add_request(ACT_CONTEXT, 16'h5555);
    add_request(ACT_PREDICT, 16'h0000);
    add_request(ACT_CLEAR, 16'h1234);
    add_request(ACT_PREDICT, 16'h0000);
    for (int r = 0; r < 3; r++) begin
      add_request(ACT_TRAIN, 16'd5);
      add_request(ACT_TRAIN, 16'd6);
      add_request(ACT_TRAIN, 16'd7);
    end
    add_request(ACT_CLEAR, 16'h0000);
    add_request(ACT_TRAIN, 16'd5);
    add_request(ACT_PREDICT, 16'h0000);
    add_request(ACT_TRAIN, 16'd6);
    add_request(ACT_PREDICT, 16'h0000);

    // zero threshold with a fresh context: empty levels never stop, so the unigram fallback answers
    wait_idle();
    write_reg(REG_THRESH, 32'd0);
    add_request(ACT_CONTEXT, 16'hBEEF);
    add_request(ACT_PREDICT, 16'h0000);

    run_phase(5'd1, 16'd0, 8'd0, 300);
    run_phase(5'd31, 16'hFFFF, 8'd255, 250);
    wait_idle();
    sender_idle_pct = 49; recv_idle_pct = 20;
    run_phase(5'd0, 16'h8000, 8'd4, 300);
    run_phase(5'd16, 16'hB000, 8'd4, 300);
    wait_idle();
    sender_idle_pct = 0; recv_idle_pct = 0;
    run_phase(5'd3, 16'h4000, 8'd1, 300);

    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
